// File: rtl/core/range_gate_delay_table_assert.svh
// ----------------------------------------------------------------------------
// Range gate delay table assertion macros
// Shared property templates for the checker of the range gate delay table.
// ----------------------------------------------------------------------------
`ifndef RANGE_GATE_DELAY_TABLE_ASSERT_SVH
`define RANGE_GATE_DELAY_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGDT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/rgdt_pkg.sv
// ----------------------------------------------------------------------------
// Range gate delay table package
// Widths, codes, defaults and shared types of the range gate delay table.
// ----------------------------------------------------------------------------
package rgdt_pkg;

    localparam int KIND_W     = 2;
    localparam int STEP_W     = 8;
    localparam int TIME_W     = 32;
    localparam int VALUE_W    = 8;
    localparam int UNITS_W    = 8;
    localparam int TICKS_W    = 16;
    localparam int STEPS_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int BEAMS_DEFAULT     = 2;
    localparam int MAX_STEPS_DEFAULT = 256;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd65535;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_ORBIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_IN_USE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_WIDTH_UNITS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH_UNITS = 2'd3;

    localparam logic [KIND_W-1:0] KIND_WR_DELAY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_DURATION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RD_STEP     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RD_TIME     = 2'd3;

    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES         = TIME_W / DIV_BITS_PER_CYCLE;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_MUL,
        ST_QUO,
        ST_ACCESS,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [TIME_W-1:0]  dividend;
        logic [TICKS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [TIME_W-1:0]  quotient;
        logic [TICKS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: rtl/core/rgdt_if.sv
// ----------------------------------------------------------------------------
// Range gate delay table channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface rgdt_cmd_if;
    import rgdt_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic               beam;
    logic [STEP_W-1:0]  step;
    logic [TIME_W-1:0]  time_ticks;
    logic [VALUE_W-1:0] value;

    modport source (output valid, kind, beam, step, time_ticks, value, input ready);
    modport sink (input valid, kind, beam, step, time_ticks, value, output ready);
endinterface

interface rgdt_res_if;
    import rgdt_pkg::*;

    logic               valid;
    logic               ready;
    logic [UNITS_W-1:0] delay_units;
    logic [UNITS_W-1:0] duration_units;
    logic [STEP_W-1:0]  step_used;
    logic               status;

    modport source (output valid, delay_units, duration_units, step_used, status,
                    input ready);
    modport sink (input valid, delay_units, duration_units, step_used, status,
                  output ready);
endinterface

// File: rtl/core/range_gate_delay_table.sv
// ----------------------------------------------------------------------------
// Range gate delay table
// Per-beam delay table by orbit step with per-beam durations.
// ----------------------------------------------------------------------------
// Commands arrive as beats on cmd: write delay, write duration, look up by
// step, or look up by orbit time. Every command gives exactly one result beat
// on res. The four registers are written through cfg_we, cfg_index and
// cfg_data; the user must do so only while no command is in flight, since
// the block itself does not enforce it. A command is taken only when the
// previous one has finished; a finished result may still wait in the output
// register while the next is taken. Writes pass through ST_ACCESS and
// ST_DONE to the result register; step lookups add ST_READ between them,
// skipped when flagged; lookups by orbit time first make two divider passes
// with a multiply between them, then the table read. A new command can be
// taken in the cycle after a result is loaded. After reset the delay RAM is
// swept to zero, one entry per cycle, over all BEAMS * MAX_STEPS entries;
// cmd.ready stays low during the sweep. When res.ready is low, the result
// holds and the block takes at most one further command, which completes
// once the output register frees up.
// ----------------------------------------------------------------------------
module range_gate_delay_table #(
    parameter int BEAMS     = rgdt_pkg::BEAMS_DEFAULT,
    parameter int MAX_STEPS = rgdt_pkg::MAX_STEPS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    rgdt_cmd_if.sink                             cmd,
    rgdt_res_if.source                           res,
    input  logic                                 cfg_we,
    input  logic [rgdt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rgdt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rgdt_pkg::*;

    localparam int DEPTH  = BEAMS * MAX_STEPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BEAM_W = (BEAMS > 1) ? $clog2(BEAMS) : 1;

    state_t state_reg, state_next;

    logic [TICKS_W-1:0] ticks_reg;
    logic [STEPS_W-1:0] steps_reg;
    logic [UNITS_W-1:0] gate_reg;
    logic [UNITS_W-1:0] pulse_reg;

    logic [KIND_W-1:0]  kind_reg;
    logic [BEAM_W-1:0]  beam_reg;
    logic [STEPS_W-1:0] step_reg;
    logic [VALUE_W-1:0] value_reg;

    logic [UNITS_W-1:0] dur_reg [BEAMS];
    logic [ADDR_W-1:0]  clr_cnt_reg;

    logic [UNITS_W-1:0] pend_dly_reg;
    logic [UNITS_W-1:0] pend_dur_reg;
    logic [STEP_W-1:0]  pend_used_reg;
    logic               pend_status_reg;

    logic               res_valid_reg;
    logic               res_valid_next;
    logic [UNITS_W-1:0] res_dly_reg;
    logic [UNITS_W-1:0] res_dur_reg;
    logic [STEP_W-1:0]  res_used_reg;
    logic               res_status_reg;

    logic               cmd_accept;
    logic               clr_last;
    logic               in_range;
    logic               is_lookup;
    logic               out_free;
    logic               res_load;
    logic [TICKS_W-1:0] ticks_eff;
    logic signed [8:0]  off_diff;
    logic signed [8:0]  off_half;
    logic [UNITS_W-1:0] off8;
    logic [ADDR_W-1:0]  item_addr;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [UNITS_W-1:0] mem_wdata;
    logic [UNITS_W-1:0] mem_rdata;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cmd_accept = cmd.valid && cmd.ready;
    assign clr_last   = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign ticks_eff  = (ticks_reg == '0) ? TICKS_W'(1) : ticks_reg;
    assign off_diff   = $signed({1'b0, gate_reg}) - $signed({1'b0, pulse_reg});
    assign off_half   = (off_diff + $signed({8'd0, off_diff[8]})) >>> 1;
    assign off8       = off_half[UNITS_W-1:0];
    assign in_range   = (step_reg < steps_reg) && (32'(step_reg) < MAX_STEPS);
    assign is_lookup  = (kind_reg == KIND_RD_STEP) || (kind_reg == KIND_RD_TIME);
    assign item_addr  = ADDR_W'(beam_reg * MAX_STEPS) + ADDR_W'(step_reg);
    assign out_free   = !res_valid_reg || res.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = (cmd.kind == KIND_RD_TIME) ? ST_MOD : ST_ACCESS;
                end
            end
            ST_MOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_QUO;
            end
            ST_QUO:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                if (kind_reg != KIND_WR_DURATION && in_range && is_lookup)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.ready        = 1'b0;
        mem_we           = 1'b0;
        mem_addr         = item_addr;
        mem_wdata        = value_reg + off8;
        div_req.start    = 1'b0;
        div_req.dividend = cmd.time_ticks;
        div_req.divisor  = ticks_eff;
        res_load         = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
            end
            ST_IDLE:
            begin
                cmd.ready     = 1'b1;
                div_req.start = cmd.valid && (cmd.kind == KIND_RD_TIME);
            end
            ST_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = TIME_W'(div_rsp.remainder) * TIME_W'(steps_reg);
            end
            ST_ACCESS:
            begin
                mem_we = (kind_reg == KIND_WR_DELAY) && in_range;
            end
            ST_DONE:
            begin
                res_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid_next = res_load ? 1'b1 : (res.ready ? 1'b0 : res_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
            ticks_reg     <= TICKS_RESET;
            steps_reg     <= STEPS_RESET;
            gate_reg      <= '0;
            pulse_reg     <= '0;
            for (int i = 0; i < BEAMS; i++)
            begin
                dur_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TICKS_PER_ORBIT:   ticks_reg <= cfg_data[TICKS_W-1:0];
                    CFG_STEPS_IN_USE:      steps_reg <= cfg_data[STEPS_W-1:0];
                    CFG_GATE_WIDTH_UNITS:  gate_reg  <= cfg_data[UNITS_W-1:0];
                    CFG_PULSE_WIDTH_UNITS: pulse_reg <= cfg_data[UNITS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_ACCESS && kind_reg == KIND_WR_DURATION)
            begin
                dur_reg[beam_reg] <= value_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            kind_reg  <= cmd.kind;
            beam_reg  <= (BEAMS == 1) ? '0 : BEAM_W'(cmd.beam);
            step_reg  <= {1'b0, cmd.step};
            value_reg <= cmd.value;
        end
        else if (state_reg == ST_QUO && div_rsp.done)
        begin
            step_reg <= div_rsp.quotient[STEPS_W-1:0];
        end

        if (state_reg == ST_ACCESS)
        begin
            pend_dly_reg    <= '0;
            pend_dur_reg    <= '0;
            pend_used_reg   <= (kind_reg == KIND_WR_DURATION) ? '0 : step_reg[STEP_W-1:0];
            pend_status_reg <= (kind_reg != KIND_WR_DURATION) && !in_range;
        end
        else if (state_reg == ST_READ)
        begin
            pend_dly_reg <= mem_rdata - off8;
            pend_dur_reg <= dur_reg[beam_reg];
        end

        if (res_load)
        begin
            res_dly_reg    <= pend_dly_reg;
            res_dur_reg    <= pend_dur_reg;
            res_used_reg   <= pend_used_reg;
            res_status_reg <= pend_status_reg;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.delay_units    = res_dly_reg;
    assign res.duration_units = res_dur_reg;
    assign res.step_used      = res_used_reg;
    assign res.status         = res_status_reg;

    rgdt_ram #(
        .WIDTH(UNITS_W),
        .DEPTH(DEPTH)
    ) u_delay_ram (
        .clk  (clk),
        .we   (mem_we),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    rgdt_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

endmodule

// File: rtl/core/rgdt_ram.sv
// ----------------------------------------------------------------------------
// Range gate delay table RAM
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rgdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/rgdt_div.sv
// ----------------------------------------------------------------------------
// Range gate delay table divider
// Restoring unsigned divider, 32 by 16 bits, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rgdt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rgdt_pkg::div_req_t req,
    output rgdt_pkg::div_rsp_t rsp
);
    import rgdt_pkg::*;

    localparam int CNT_W = $clog2(DIV_CYCLES);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [TIME_W-1:0]  num_reg;
    logic [TICKS_W-1:0] rem_reg;
    logic [TICKS_W-1:0] den_reg;
    logic [TIME_W-1:0]  num_next;
    logic [TICKS_W-1:0] rem_next;

    always_comb
    begin
        logic [TICKS_W:0] trial;
        num_next = num_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial    = {rem_next, num_next[TIME_W-1]};
            num_next = {num_next[TIME_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                trial       = trial - {1'b0, den_reg};
                num_next[0] = 1'b1;
            end
            rem_next = trial[TICKS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = num_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/core/rgdt_checker.sv
// ----------------------------------------------------------------------------
// Range gate delay table checker
// Port-level assertions for the range gate delay table, bound to the top.
// ----------------------------------------------------------------------------
`include "range_gate_delay_table_assert.svh"

module rgdt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [rgdt_pkg::UNITS_W-1:0]  delay_units,
    input logic [rgdt_pkg::UNITS_W-1:0]  duration_units,
    input logic [rgdt_pkg::STEP_W-1:0]   step_used,
    input logic                          status
);
    import rgdt_pkg::*;

    // A result beat that is not taken stays offered.
    `RGDT_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `RGDT_ASSERT_NEXT(a_res_stable, clk, rst_n, res_valid && !res_ready, $stable(delay_units) && $stable(duration_units) && $stable(step_used) && $stable(status), "result payload changed while stalled")

    // An out-of-range step reports no table contents.
    `RGDT_ASSERT_SAME(a_flag_zero, clk, rst_n, res_valid && status, delay_units == '0 && duration_units == '0, "flagged result carries data")

    // Commands are worked one at a time.
    `RGDT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready, "command taken while another is in flight")

endmodule

bind range_gate_delay_table rgdt_checker u_rgdt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .delay_units   (res.delay_units),
    .duration_units(res.duration_units),
    .step_used     (res.step_used),
    .status        (res.status)
);
